// File: rtl/core/bpfa_pkg.sv
package bpfa_pkg;

   // Default pool geometry.
   localparam int BLOCK_CAP_DEF  = 64;
   localparam int MAX_BLOCKS_DEF = 16;

   // Fixed field widths of the stream and register interfaces.
   localparam int FREE_INDEX_W   = 10;
   localparam int SLOT_INDEX_W   = 10;
   localparam int BLOCK_NUMBER_W = 4;
   localparam int SLOT_IN_BLK_W  = 6;
   localparam int BYTE_OFFSET_W  = 22;
   localparam int STATUS_W       = 2;
   localparam int ALLOC_COUNT_W  = 11;
   localparam int BLOCKS_W       = 5;
   localparam int OBJ_SIZE_W     = 13;
   localparam int ALIGN_W        = 4;
   localparam int RSIZE_W        = 17;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 64;
   localparam int RSP_TUSER_W    = 3;

   // Register reset values.
   localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RESET = 13'd4;
   localparam logic [ALIGN_W-1:0]    ALIGN_RESET    = 4'd2;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_BAD_FREE  = 2'd2
   } status_code_type;

   typedef enum logic {
      CSR_OBJECT_SIZE = 1'b0,
      CSR_ALIGN_LOG2  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic mul;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_slot;
      logic out_busy;
   } dp_stat_type;

endpackage

// File: rtl/core/bpfa_ram.sv
module bpfa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/bpfa_csr.sv
module bpfa_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [bpfa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bpfa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [bpfa_pkg::RSIZE_W-1:0]       rsize
);
   import bpfa_pkg::*;

   logic [OBJ_SIZE_W-1:0] obj_size_ff, obj_size_in;
   logic [ALIGN_W-1:0]    align_ff, align_in;
   logic [RSIZE_W-1:0]    rsize_ff, rsize_in;
   logic [RSIZE_W-1:0]    round_sum;
   logic                  wr_en;
   csr_index_type         index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign index      = csr_index_type'(csr_paddr[2]);

   always_comb begin
      obj_size_in = obj_size_ff;
      align_in    = align_ff;
      if (wr_en) begin
         unique case (index)
            CSR_OBJECT_SIZE: obj_size_in = csr_pwdata[OBJ_SIZE_W-1:0];
            CSR_ALIGN_LOG2:  align_in    = csr_pwdata[ALIGN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_OBJECT_SIZE: csr_prdata = CSR_DATA_W'(obj_size_ff);
         CSR_ALIGN_LOG2:  csr_prdata = CSR_DATA_W'(align_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Object size rounded up to the alignment; refreshed every cycle.
   assign round_sum = RSIZE_W'(obj_size_ff) + (RSIZE_W'(1) << align_ff) - RSIZE_W'(1);
   assign rsize_in  = (round_sum >> align_ff) << align_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_size_ff <= OBJ_SIZE_RESET;
         align_ff    <= ALIGN_RESET;
      end else begin
         obj_size_ff <= obj_size_in;
         align_ff    <= align_in;
      end
      rsize_ff <= rsize_in;
   end

   assign rsize = rsize_ff;

endmodule

// File: rtl/core/bpfa_ctrl.sv
module bpfa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  bpfa_pkg::dp_stat_type      stat,
   output bpfa_pkg::ctrl_cmd_type     cmd
);
   import bpfa_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = stat.has_slot ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cmd.load_req = (state_ff == ST_IDLE) & req_tvalid;
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.mul      = (state_ff == ST_MUL);
      cmd.finish   = (state_ff == ST_DONE) & ~stat.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/bpfa_datapath.sv
module bpfa_datapath #(
   parameter int BLOCK_CAP  = bpfa_pkg::BLOCK_CAP_DEF,
   parameter int MAX_BLOCKS = bpfa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bpfa_pkg::ctrl_cmd_type              cmd,
   output bpfa_pkg::dp_stat_type               stat,
   input  logic                                req_cmd,
   input  logic [bpfa_pkg::FREE_INDEX_W-1:0]   req_free_index,
   input  logic [bpfa_pkg::RSIZE_W-1:0]        rsize,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bpfa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [bpfa_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);
   import bpfa_pkg::*;

   localparam int POOL_SLOTS = BLOCK_CAP * MAX_BLOCKS;
   localparam int ADDR_W     = $clog2(POOL_SLOTS);
   localparam int DEPTH_W    = $clog2(POOL_SLOTS + 1);
   localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W      = (DEPTH_W > FREE_INDEX_W) ? DEPTH_W : FREE_INDEX_W;
   // Exact division by BLOCK_CAP through a rounded-up reciprocal.
   localparam int SH         = ADDR_W + $clog2(BLOCK_CAP);
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(BLOCK_CAP) - 64'd1) / 64'(BLOCK_CAP);
   localparam logic [ADDR_W:0] RECIP = RECIP_L[ADDR_W:0];
   localparam int QPROD_W    = 2 * ADDR_W + 1;
   localparam int OPROD_W    = ADDR_W + RSIZE_W;

   // Stack state. Positions below fresh_lim_ff hold the untouched tail of the
   // most recently opened block and are computed, never read from memory.
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [BLK_W-1:0]   blocks_ff, blocks_in;
   logic [DEPTH_W-1:0] fresh_lim_ff, fresh_lim_in;
   logic [ADDR_W-1:0]  fresh_base_ff, fresh_base_in;

   // Item registers.
   logic                    cmd_ff;
   logic [FREE_INDEX_W-1:0] fidx_ff;
   logic [ADDR_W-1:0]       idx_ff, idx_in;
   logic                    use_mem_ff, use_mem_in;
   logic                    has_slot_ff, has_slot_in;
   logic                    newb_ff, newb_in;
   status_code_type         status_ff, status_in;
   logic [BLK_W-1:0]        q_ff;
   logic [BYTE_OFFSET_W-1:0] off_ff;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff;
   logic [RSP_TUSER_W-1:0]   rsp_user_ff;

   logic [DEPTH_W-1:0] limit;
   logic [DEPTH_W-1:0] pos;
   logic [CMP_W-1:0]   fidx_cmp;
   logic [CMP_W-1:0]   limit_cmp;
   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [ADDR_W-1:0]  ram_wdata, ram_rdata;
   logic [ADDR_W-1:0]  idx_src;
   logic [QPROD_W-1:0] qprod;
   logic [OPROD_W-1:0] oprod;
   logic [ADDR_W-1:0]  rem;
   logic [SLOT_INDEX_W-1:0]   f_slot;
   logic [BLOCK_NUMBER_W-1:0] f_block;
   logic [SLOT_IN_BLK_W-1:0]  f_inblk;
   logic [BYTE_OFFSET_W-1:0]  f_off;
   logic [ALLOC_COUNT_W-1:0]  f_count;
   logic [BLOCKS_W-1:0]       f_blocks;

   assign limit     = DEPTH_W'(blocks_ff) * DEPTH_W'(BLOCK_CAP);
   assign pos       = depth_ff - DEPTH_W'(1);
   assign fidx_cmp  = CMP_W'(fidx_ff);
   assign limit_cmp = CMP_W'(limit);

   always_comb begin
      depth_in      = depth_ff;
      blocks_in     = blocks_ff;
      fresh_lim_in  = fresh_lim_ff;
      fresh_base_in = fresh_base_ff;
      idx_in        = idx_ff;
      use_mem_in    = 1'b0;
      has_slot_in   = 1'b0;
      newb_in       = 1'b0;
      status_in     = STATUS_OK;
      ram_we        = 1'b0;
      ram_waddr     = ADDR_W'(depth_ff);
      ram_wdata     = ADDR_W'(fidx_ff);
      ram_re        = 1'b0;
      ram_raddr     = ADDR_W'(pos);
      if (cmd_ff == CMD_ALLOC) begin
         priority if (depth_ff != '0) begin
            depth_in    = pos;
            has_slot_in = 1'b1;
            if (pos < fresh_lim_ff) begin
               idx_in = fresh_base_ff + ADDR_W'(BLOCK_CAP - 1) - ADDR_W'(pos);
            end else begin
               use_mem_in = 1'b1;
               ram_re     = cmd.exec;
            end
         end else if (blocks_ff < BLK_W'(MAX_BLOCKS)) begin
            // Open a block: hand out its slot 0, the rest become fresh entries.
            fresh_base_in = ADDR_W'(limit);
            fresh_lim_in  = DEPTH_W'(BLOCK_CAP - 1);
            depth_in      = DEPTH_W'(BLOCK_CAP - 1);
            blocks_in     = blocks_ff + BLK_W'(1);
            idx_in        = ADDR_W'(limit);
            has_slot_in   = 1'b1;
            newb_in       = 1'b1;
         end else begin
            status_in = STATUS_EXHAUSTED;
         end
      end else begin
         if ((fidx_cmp < limit_cmp) && (depth_ff < limit)) begin
            ram_we   = cmd.exec;
            depth_in = depth_ff + DEPTH_W'(1);
            // A push onto a fresh position overwrites it, so the fresh range shrinks.
            if (depth_ff < fresh_lim_ff) begin
               fresh_lim_in = depth_ff;
            end
         end else begin
            status_in = STATUS_BAD_FREE;
         end
      end
   end

   bpfa_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (POOL_SLOTS)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign idx_src = use_mem_ff ? ram_rdata : idx_ff;
   assign qprod   = QPROD_W'(idx_src) * QPROD_W'(RECIP);
   assign oprod   = OPROD_W'(idx_src) * OPROD_W'(rsize);

   assign rem = idx_ff - ADDR_W'(q_ff) * ADDR_W'(BLOCK_CAP);

   always_comb begin
      f_slot   = has_slot_ff ? SLOT_INDEX_W'(idx_ff) : '0;
      f_block  = has_slot_ff ? BLOCK_NUMBER_W'(q_ff) : '0;
      f_inblk  = has_slot_ff ? SLOT_IN_BLK_W'(rem) : '0;
      f_off    = has_slot_ff ? off_ff : '0;
      f_count  = ALLOC_COUNT_W'(limit - depth_ff);
      f_blocks = BLOCKS_W'(blocks_ff);
   end

   assign stat.has_slot = has_slot_in;
   assign stat.out_busy = rsp_valid_ff & ~rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         blocks_ff    <= '0;
         fresh_lim_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            depth_ff     <= depth_in;
            blocks_ff    <= blocks_in;
            fresh_lim_ff <= fresh_lim_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_cmd;
         fidx_ff <= req_free_index;
      end
      if (cmd.exec) begin
         fresh_base_ff <= fresh_base_in;
         idx_ff        <= idx_in;
         use_mem_ff    <= use_mem_in;
         has_slot_ff   <= has_slot_in;
         newb_ff       <= newb_in;
         status_ff     <= status_in;
      end
      if (cmd.mul) begin
         idx_ff     <= idx_src;
         use_mem_ff <= 1'b0;
         q_ff       <= BLK_W'(qprod >> SH);
         off_ff     <= BYTE_OFFSET_W'(oprod);
      end
      if (cmd.finish) begin
         rsp_data_ff <= RSP_TDATA_W'({f_blocks, f_count, f_off, f_inblk, f_block, f_slot});
         rsp_user_ff <= {status_ff, has_slot_ff & newb_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/core/block_pool_free_index_allocator_core.sv
// Fixed-size object pool allocator. Allocations pop slot indices from a LIFO
// free stack held in a single-port-per-side RAM; when the stack is empty a new
// block of BLOCK_CAP slots is opened, slot 0 of it is returned and its other
// slots become available lowest first without any fill sweep (they are
// generated from a base and a fresh-range counter until overwritten by frees).
// Frees push the index back; out-of-range frees and frees while no slot is
// allocated report status 2, an allocation with every slot of all MAX_BLOCKS
// blocks taken reports status 1. One result beat follows every request beat.
// An allocation goes through accept, stack access, registered index multiply
// for block number and byte offset, and result; a free or failed allocation
// skips the multiply. The next request is taken once the result is in the
// output register, even while it waits for rsp_tready. No clearing pass is
// needed after reset. The rounded object size is registered from the CSRs.
module block_pool_free_index_allocator_core #(
   parameter int BLOCK_CAP  = bpfa_pkg::BLOCK_CAP_DEF,
   parameter int MAX_BLOCKS = bpfa_pkg::MAX_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [9:0] free_index, [15:10] zero
   input  logic [bpfa_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [9:0] slot_index, [13:10] block_number, [19:14] slot_in_block,
   // [41:20] byte_offset, [52:42] allocated_count, [57:53] blocks_in_use,
   // [63:58] zero
   output logic [bpfa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] block_opened, [2:1] status
   output logic [bpfa_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bpfa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bpfa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bpfa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import bpfa_pkg::*;

   ctrl_cmd_type        cmd;
   dp_stat_type         stat;
   logic [RSIZE_W-1:0]  rsize;

   bpfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .rsize       (rsize)
   );

   bpfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bpfa_datapath #(
      .BLOCK_CAP  (BLOCK_CAP),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cmd        (req_tuser),
      .req_free_index (req_tdata[FREE_INDEX_W-1:0]),
      .rsize          (rsize),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser)
   );

endmodule
